// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the repeat index mapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/trim_pkg.sv
// Package: shared types and register indexes of the repeat index mapper
`default_nettype none
package trim_pkg;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ERR_W = 2;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [2*DATA_W-1:0] dword_t;
    typedef logic [ERR_W-1:0] err_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes
    localparam cfg_idx_t REG_RANK         = 3'd0;
    localparam cfg_idx_t REG_OUT_STRIDE_0 = 3'd1;
    localparam cfg_idx_t REG_OUT_STRIDE_1 = 3'd2;
    localparam cfg_idx_t REG_SRC_SIZE_0   = 3'd3;
    localparam cfg_idx_t REG_SRC_SIZE_1   = 3'd4;
    localparam cfg_idx_t REG_SRC_STRIDE_0 = 3'd5;
    localparam cfg_idx_t REG_SRC_STRIDE_1 = 3'd6;

    // Error codes
    localparam err_t ERR_NONE     = 2'd0;
    localparam err_t ERR_ZERO_DIV = 2'd1;
    localparam err_t ERR_OVERFLOW = 2'd2;
endpackage
`default_nettype wire

// File: rtl/core/trim_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none
module trim_div #(
    parameter int W      = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [W-1:0]      dividend,
    input  wire logic [W-1:0]      divisor,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [W-1:0]           quotient,
    output logic [W-1:0]           remainder,
    output logic [SIDE_W-1:0]      side_out
);
    logic              vld_reg  [1:W];
    logic [W-1:0]      rem_reg  [1:W];
    logic [W-1:0]      dq_reg   [1:W];
    logic [SIDE_W-1:0] side_reg [1:W];

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic              cur_vld;
        logic [W-1:0]      cur_rem;
        logic [W-1:0]      cur_dq;
        logic [SIDE_W-1:0] cur_side;
        logic [W:0]        trial;
        logic              ge;
        logic [W:0]        diff;

        if (g == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_rem  = '0;
            assign cur_dq   = dividend;
            assign cur_side = side_in;
        end else begin : g_mid
            assign cur_vld  = vld_reg[g];
            assign cur_rem  = rem_reg[g];
            assign cur_dq   = dq_reg[g];
            assign cur_side = side_reg[g];
        end

        // shift in next dividend bit, subtract when it fits
        always_comb begin
            trial = {cur_rem, cur_dq[W-1]};
            ge    = trial >= {1'b0, divisor};
            diff  = trial - {1'b0, divisor};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g+1]  <= ge ? diff[W-1:0] : trial[W-1:0];
                dq_reg[g+1]   <= {cur_dq[W-2:0], ge};
                side_reg[g+1] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[W];
    assign quotient  = dq_reg[W];
    assign remainder = rem_reg[W];
    assign side_out  = side_reg[W];
endmodule
`default_nettype wire

// File: rtl/core/tensor_repeat_index_map.sv
// Top level: repeat (tile) index mapper, output index to source index
// Usage:
//   Input channel s_valid/s_ready carries one word, s_out_position, the
//   linear index of an element of the tiled output tensor. Result channel
//   m_valid/m_ready carries m_src_position and m_error_code (0 ok, 1 zero
//   stride or size, 2 overflow past 32 bits; position is zero on error).
//   Registers are written through cfg_wr_en/cfg_index/cfg_wdata while the
//   block is idle; indexes above 6 are ignored.
//   The datapath has four 32-stage bit-per-stage dividers (quotient and
//   remainder per dimension, then the modulo by source size), two multiply
//   stages and one sum stage. Throughput is one word per cycle while the
//   receiver does not stall. When the receiver stalls the whole pipeline
//   holds and s_ready drops in the same cycle; nothing is lost or repeated.
//   A bubble in the output register lets a new word in even while m_ready
//   is low. Reset clears all valid bits and sets every config register to 1.
`default_nettype none
module tensor_repeat_index_map #(
    parameter int MAX_DIMS = 2
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire trim_pkg::cfg_idx_t        cfg_index,
    input  wire trim_pkg::word_t           cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire trim_pkg::word_t           s_out_position,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output trim_pkg::word_t                m_src_position,
    output trim_pkg::err_t                 m_error_code
);
    import trim_pkg::*;
    `include "assert_macros.svh"

    logic [1:0] rank_reg;
    word_t out_stride_0_reg, out_stride_1_reg;
    word_t src_size_0_reg, src_size_1_reg;
    word_t src_stride_0_reg, src_stride_1_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg         <= 2'd1;
            out_stride_0_reg <= 32'd1;
            out_stride_1_reg <= 32'd1;
            src_size_0_reg   <= 32'd1;
            src_size_1_reg   <= 32'd1;
            src_stride_0_reg <= 32'd1;
            src_stride_1_reg <= 32'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RANK:         rank_reg         <= cfg_wdata[1:0];
                REG_OUT_STRIDE_0: out_stride_0_reg <= cfg_wdata;
                REG_OUT_STRIDE_1: out_stride_1_reg <= cfg_wdata;
                REG_SRC_SIZE_0:   src_size_0_reg   <= cfg_wdata;
                REG_SRC_SIZE_1:   src_size_1_reg   <= cfg_wdata;
                REG_SRC_STRIDE_0: src_stride_0_reg <= cfg_wdata;
                REG_SRC_STRIDE_1: src_stride_1_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Second dimension active only when rank asks for it and hardware allows
    logic two_dims;
    assign two_dims = (MAX_DIMS > 1) && (rank_reg >= 2'd2);

    // Global advance: output register empty or being taken
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Dimension zero: position / out_stride_0
    logic  d0_vld;
    word_t d0_q, d0_r;
    logic  d0_side;
    trim_div #(.W(DATA_W), .SIDE_W(1)) u_div_d0 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid && en), .dividend(s_out_position),
        .divisor(out_stride_0_reg), .side_in(1'b0),
        .out_valid(d0_vld), .quotient(d0_q), .remainder(d0_r), .side_out(d0_side)
    );

    // Dimension zero: quotient mod src_size_0, remainder rides along
    logic  m0_vld;
    word_t m0_q, m0_r, m0_side;
    trim_div #(.W(DATA_W), .SIDE_W(DATA_W)) u_mod_d0 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d0_vld && !d0_side), .dividend(d0_q),
        .divisor(src_size_0_reg), .side_in(d0_r),
        .out_valid(m0_vld), .quotient(m0_q), .remainder(m0_r), .side_out(m0_side)
    );

    // Dimension zero product
    logic   p0_vld_reg;
    dword_t p0_term_reg;
    word_t  p0_rem_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
        end else if (en) begin
            p0_vld_reg <= m0_vld;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            p0_term_reg <= dword_t'(m0_r) * dword_t'(src_stride_0_reg);
            p0_rem_reg  <= m0_side;
        end
    end

    // Dimension one: remainder / out_stride_1, term zero rides along
    logic   d1_vld;
    word_t  d1_q, d1_r;
    dword_t d1_side;
    trim_div #(.W(DATA_W), .SIDE_W(2*DATA_W)) u_div_d1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(p0_vld_reg), .dividend(p0_rem_reg),
        .divisor(out_stride_1_reg), .side_in(p0_term_reg),
        .out_valid(d1_vld), .quotient(d1_q), .remainder(d1_r), .side_out(d1_side)
    );

    // Dimension one: quotient mod src_size_1
    logic   m1_vld;
    word_t  m1_q, m1_r;
    dword_t m1_side;
    trim_div #(.W(DATA_W), .SIDE_W(2*DATA_W)) u_mod_d1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d1_vld && (d1_r == d1_r)), .dividend(d1_q),
        .divisor(src_size_1_reg), .side_in(d1_side),
        .out_valid(m1_vld), .quotient(m1_q), .remainder(m1_r), .side_out(m1_side)
    );

    // Dimension one product
    logic   p1_vld_reg;
    dword_t p1_term_reg;
    dword_t p1_t0_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= m1_vld;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_term_reg <= dword_t'(m1_r) * dword_t'(src_stride_1_reg);
            p1_t0_reg   <= m1_side;
        end
    end

    // Sum, error checks, output register
    logic            zero_div;
    logic [DATA_W:0] sum;
    logic            ovf;
    word_t           pos_next;
    err_t            err_next;
    always_comb begin
        zero_div = (out_stride_0_reg == '0) || (src_size_0_reg == '0) ||
                   (two_dims && ((out_stride_1_reg == '0) || (src_size_1_reg == '0)));
        sum = {1'b0, p1_t0_reg[DATA_W-1:0]} +
              (two_dims ? {1'b0, p1_term_reg[DATA_W-1:0]} : '0);
        ovf = (p1_t0_reg[2*DATA_W-1:DATA_W] != '0) ||
              (two_dims && ((p1_term_reg[2*DATA_W-1:DATA_W] != '0) || sum[DATA_W]));
        if (zero_div) begin
            pos_next = '0;
            err_next = ERR_ZERO_DIV;
        end else if (ovf) begin
            pos_next = '0;
            err_next = ERR_OVERFLOW;
        end else begin
            pos_next = sum[DATA_W-1:0];
            err_next = ERR_NONE;
        end
    end

    word_t pos_reg;
    err_t  err_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p1_vld_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg <= pos_next;
            err_reg <= err_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_src_position = pos_reg;
    assign m_error_code   = err_reg;

    `ASSERT_IMPL(a_err_pos_zero, m_valid_reg && (err_reg != ERR_NONE), pos_reg == '0,
        "error word must carry zero position")
    `ASSERT_IMPL(a_err_code_range, m_valid_reg, err_reg <= ERR_OVERFLOW,
        "error code out of range")
    `ASSERT_NEXT(a_stall_holds, m_valid_reg && !m_ready,
        m_valid_reg && $stable(pos_reg) && $stable(err_reg), "stalled result changed")
    `ASSERT_IMPL(a_ready_stall, m_valid_reg && !m_ready, !s_ready,
        "input taken during output stall")
endmodule
`default_nettype wire
